>>> rtl/bflp_pkg.sv
// Shared constants, command/status types and character codes for the brace frame line parser.
package bflp_pkg;

  localparam int LINE_BYTES  = 96;
  localparam int BUF_DEPTH   = LINE_BYTES - 1;
  localparam int PTR_W       = $clog2(LINE_BYTES);
  localparam int DEV_ID_MAX  = 8;
  localparam int EVENT_MAX   = 16;
  localparam int CNT_W       = $clog2(EVENT_MAX);
  localparam int TYPE_MAX    = 2;
  localparam int IDLE_W      = 16;
  localparam int PACK_W      = 56;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam logic REG_IDLE_LIMIT = 1'b0;
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 16'd500;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;

  typedef struct packed {
    logic in_rdy;
    logic in_take;
    logic scan_en;
    logic emit_rd;
    logic emit_ld;
  } bflp_ctrl_t;

  typedef struct packed {
    logic flush_req;
    logic scan_end;
    logic scan_ok;
    logic out_busy;
    logic emit_last;
  } bflp_stat_t;

endpackage

>>> rtl/bflp_in_if.sv
// Input channel: received byte or empty poll tick.
interface bflp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
  modport monitor (input valid, input cmd, input rx_byte, input ready);
endinterface

>>> rtl/bflp_out_if.sv
// Result channel: one parsed frame event character per transaction.
interface bflp_out_if;
  logic        valid;
  logic        ready;
  logic [55:0] dev_id_packed;
  logic [2:0]  dev_id_len;
  logic [3:0]  frame_type;
  logic [3:0]  event_len;
  logic [7:0]  event_char;
  logic [3:0]  char_index;
  logic        last;

  modport source (output valid, output dev_id_packed, output dev_id_len, output frame_type,
                  output event_len, output event_char, output char_index, output last,
                  input ready);
  modport sink (input valid, input dev_id_packed, input dev_id_len, input frame_type,
                input event_len, input event_char, input char_index, input last,
                output ready);
  modport monitor (input valid, input dev_id_packed, input dev_id_len, input frame_type,
                   input event_len, input event_char, input char_index, input last,
                   input ready);
endinterface

>>> rtl/bflp_ctrl.sv
// Controller state machine: accept, scan, and result emission sequencing.
module bflp_ctrl
  import bflp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  bflp_stat_t stat,
  output bflp_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_EMIT_RD = 4'b0100,
    ST_EMIT_LD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    ctrl         = '0;
    case (state_r)
      ST_IDLE: begin
        ctrl.in_rdy  = 1'b1;
        ctrl.in_take = in_valid;
        if (in_valid && stat.flush_req) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        ctrl.scan_en = 1'b1;
        if (stat.scan_end) state_nxt = stat.scan_ok ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        ctrl.emit_rd = 1'b1;
        if (!stat.out_busy) state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        ctrl.emit_ld = 1'b1;
        state_nxt    = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> rtl/bflp_dp.sv
// Datapath: line buffer memory, idle counter, byte-serial frame scanner and output register.
module bflp_dp
  import bflp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDLE_W-1:0] idle_limit,
  input  bflp_ctrl_t        ctrl,
  output bflp_stat_t        stat,
  bflp_in_if.sink           in_ch,
  bflp_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    PH_BRACE = 4'b0001,
    PH_DEV   = 4'b0010,
    PH_TYPE  = 4'b0100,
    PH_EVENT = 4'b1000
  } phase_t;

  localparam logic [CNT_W-1:0] DEV_LIM  = CNT_W'(DEV_ID_MAX - 1);
  localparam logic [CNT_W-1:0] TYPE_LIM = CNT_W'(TYPE_MAX);
  localparam logic [CNT_W-1:0] EV_LIM   = CNT_W'(EVENT_MAX - 1);

  logic [7:0]        line_buf_r [BUF_DEPTH];
  logic [7:0]        rdata_r;
  logic [PTR_W-1:0]  rd_addr;

  logic [PTR_W-1:0]  fill_r, fill_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt, idle_inc;
  logic              wr_en, is_term;
  logic              flush_req, scan_end, scan_ok, emit_last, out_busy;

  phase_t            phase_r, phase_nxt;
  logic [PTR_W-1:0]  len_r, len_nxt, pos_r, pos_nxt, ev_start_r, ev_start_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PACK_W-1:0] packed_r, packed_nxt;
  logic [2:0]        id_len_r, id_len_nxt;
  logic [3:0]        ftype_r, ftype_nxt;
  logic [3:0]        ev_len_r, ev_len_nxt;
  logic [3:0]        res_r, res_nxt, res_cnt;
  logic              at_end, ev_done, is_digit;

  logic              out_valid_r, out_valid_nxt;
  logic [PACK_W-1:0] opacked_r;
  logic [2:0]        oid_len_r;
  logic [3:0]        oftype_r;
  logic [3:0]        oev_len_r;
  logic [7:0]        ochar_r;
  logic [3:0]        oidx_r;
  logic              olast_r;

  // intake: buffer fill, idle count, flush decision
  always_comb begin
    is_term   = (in_ch.rx_byte == CHAR_LF) || (in_ch.rx_byte == CHAR_CR);
    idle_inc  = idle_r + IDLE_W'(1);
    wr_en     = 1'b0;
    flush_req = 1'b0;
    idle_nxt  = idle_r;
    if (in_ch.cmd == CMD_BYTE) begin
      idle_nxt = '0;
      if (is_term)                           flush_req = (fill_r != '0);
      else if (fill_r < PTR_W'(BUF_DEPTH))   wr_en = 1'b1;
      else                                   flush_req = 1'b1;
    end else if (fill_r != '0) begin
      if (idle_inc >= idle_limit) begin
        flush_req = 1'b1;
        idle_nxt  = '0;
      end else begin
        idle_nxt = idle_inc;
      end
    end
    fill_nxt = fill_r;
    if (ctrl.in_take) begin
      if (flush_req)  fill_nxt = '0;
      else if (wr_en) fill_nxt = fill_r + PTR_W'(1);
    end
  end

  // scanner: one buffered byte per cycle
  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    packed_nxt   = packed_r;
    id_len_nxt   = id_len_r;
    ftype_nxt    = ftype_r;
    ev_start_nxt = ev_start_r;
    ev_len_nxt   = ev_len_r;
    res_nxt      = res_r;
    at_end       = (pos_r == len_r);
    is_digit     = (rdata_r >= CHAR_0) && (rdata_r <= CHAR_9);
    ev_done      = (phase_r == PH_EVENT) && ((cnt_r == EV_LIM) || (rdata_r == CHAR_RBRACE));
    scan_end     = ctrl.scan_en && (at_end || ev_done);
    scan_ok      = !at_end && ev_done;
    if (ctrl.in_take && flush_req) begin
      phase_nxt  = PH_BRACE;
      len_nxt    = fill_r;
      pos_nxt    = '0;
      cnt_nxt    = '0;
      packed_nxt = '0;
      ftype_nxt  = '0;
      res_nxt    = '0;
    end else if (ctrl.scan_en && !at_end) begin
      pos_nxt = pos_r + PTR_W'(1);
      case (phase_r)
        PH_BRACE: begin
          if (rdata_r == CHAR_LBRACE) phase_nxt = PH_DEV;
        end
        PH_DEV: begin
          if ((cnt_r == DEV_LIM) || (rdata_r == CHAR_COMMA)) begin
            id_len_nxt = cnt_r[2:0];
            cnt_nxt    = '0;
            phase_nxt  = PH_TYPE;
          end else begin
            packed_nxt[{cnt_r[2:0], 3'b000} +: 8] = rdata_r;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        PH_TYPE: begin
          if ((cnt_r == TYPE_LIM) || (rdata_r == CHAR_COMMA)) begin
            cnt_nxt      = '0;
            ev_start_nxt = pos_r + PTR_W'(1);
            phase_nxt    = PH_EVENT;
          end else begin
            if (cnt_r == '0) ftype_nxt = is_digit ? 4'(rdata_r - CHAR_0) : 4'd0;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        PH_EVENT: begin
          if (ev_done) ev_len_nxt = 4'(cnt_r);
          else         cnt_nxt    = cnt_r + CNT_W'(1);
        end
        default: phase_nxt = PH_BRACE;
      endcase
    end else if (ctrl.emit_ld) begin
      res_nxt = res_r + 4'd1;
    end
  end

  assign res_cnt   = (ev_len_r == 4'd0) ? 4'd1 : ev_len_r;
  assign emit_last = (res_r == res_cnt - 4'd1);
  assign out_busy  = out_valid_r;

  assign stat = '{flush_req: flush_req, scan_end: scan_end, scan_ok: scan_ok,
                  out_busy: out_busy, emit_last: emit_last};

  always_comb begin
    if (ctrl.emit_rd)      rd_addr = ev_start_r + PTR_W'(res_r);
    else if (ctrl.scan_en) rd_addr = pos_r + PTR_W'(1);
    else                   rd_addr = '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.in_take && wr_en) line_buf_r[fill_r] <= in_ch.rx_byte;
    if (rd_addr < PTR_W'(BUF_DEPTH)) rdata_r <= line_buf_r[rd_addr];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (ctrl.emit_ld) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      idle_r      <= '0;
      phase_r     <= PH_BRACE;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      if (ctrl.in_take) idle_r <= idle_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result fields are held apart from the scanner so a waiting result survives the next scan
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    packed_r   <= packed_nxt;
    id_len_r   <= id_len_nxt;
    ftype_r    <= ftype_nxt;
    ev_start_r <= ev_start_nxt;
    ev_len_r   <= ev_len_nxt;
    res_r      <= res_nxt;
    if (ctrl.emit_ld) begin
      opacked_r <= packed_r;
      oid_len_r <= id_len_r;
      oftype_r  <= ftype_r;
      oev_len_r <= ev_len_r;
      ochar_r   <= (ev_len_r == 4'd0) ? 8'd0 : rdata_r;
      oidx_r    <= (ev_len_r == 4'd0) ? 4'd0 : res_r;
      olast_r   <= emit_last;
    end
  end

  assign in_ch.ready = ctrl.in_rdy;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.dev_id_packed = opacked_r;
  assign out_ch.dev_id_len    = oid_len_r;
  assign out_ch.frame_type    = oftype_r;
  assign out_ch.event_len     = oev_len_r;
  assign out_ch.event_char    = ochar_r;
  assign out_ch.char_index    = oidx_r;
  assign out_ch.last          = olast_r;

endmodule

>>> rtl/brace_frame_line_parser_unit.sv
// Top level: brace frame line parser with APB idle-limit register.
// Bytes and ticks that do not complete a line are accepted while the controller is idle.
// A completing transaction scans the buffer at 1 byte/cycle from the registered
// memory read port; results are then emitted one character at a time, each read
// from the buffer and loaded once out ready has taken the previous result;
// the last result may wait while input resumes.
// Synchronous active-low reset empties the buffer, clears the idle count, sets idle_limit to 500.
module brace_frame_line_parser_unit
  import bflp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  bflp_in_if.sink            in_if,
  bflp_out_if.source         out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [IDLE_W-1:0] idle_limit_r, idle_limit_nxt;
  logic              reg_sel;
  bflp_ctrl_t        ctrl;
  bflp_stat_t        stat;

  assign reg_sel = (paddr[PADDR_W-1] == REG_IDLE_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? PDATA_W'(idle_limit_r) : '0;

  always_comb begin
    idle_limit_nxt = idle_limit_r;
    if (psel && penable && pwrite && reg_sel) idle_limit_nxt = pwdata[IDLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idle_limit_r <= IDLE_LIMIT_RST;
    else        idle_limit_r <= idle_limit_nxt;
  end

  bflp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  bflp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .idle_limit (idle_limit_r),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

endmodule

>>> rtl/bflp_chk.sv
// Port-level checker for the brace frame line parser, bound to the top level.
module bflp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_event_len,
  input logic [7:0] out_event_char,
  input logic [3:0] out_char_index,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_char)
      && $stable(out_char_index) && $stable(out_last))
    else $error("result changed while stalled");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_len != 4'd0) |-> (out_char_index < out_event_len))
    else $error("char_index beyond event length");

  a_empty_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_len == 4'd0) |->
      out_last && (out_char_index == 4'd0) && (out_event_char == 8'd0))
    else $error("empty event result malformed");

  a_no_intake_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while frame results pending");

endmodule

bind brace_frame_line_parser_unit bflp_chk u_bflp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_event_len  (out_if.event_len),
  .out_event_char (out_if.event_char),
  .out_char_index (out_if.char_index),
  .out_last       (out_if.last)
);
